// ===== rtl/line_centroid_steering_core_assert.svh =====
// assertion macros for the line centroid steering core
// depends on nothing; taken in by the top level with `include
`ifndef LINE_CENTROID_STEERING_CORE_ASSERT_SVH
`define LINE_CENTROID_STEERING_CORE_ASSERT_SVH

// same-cycle implication
`define LCS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lcs assertion failed");

// next-cycle implication
`define LCS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lcs assertion failed");

`endif

// ===== rtl/lcs_pkg.sv =====
// shared types, constants and widths for the line centroid steering core
// depends on nothing
package lcs_pkg;

   localparam int ROW_WIDTH_DEF  = 320;
   localparam int ROW_CENTRE_DEF = 160;

   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] REG_BASE_SPEED = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_STEER_GAIN = 8'd1;

   localparam logic [7:0]  BASE_SPEED_RST = 8'd60;
   localparam logic [15:0] STEER_GAIN_RST = 16'hFF80;

   localparam int SUM_W   = 16;
   localparam int TOTAL_W = 9;

   localparam logic CMD_CALIBRATE = 1'b0;
   localparam logic CMD_TRACK     = 1'b1;

   typedef struct packed {
      logic [7:0]         row_min;
      logic [7:0]         row_max;
      logic [SUM_W-1:0]   offset_sum;
      logic [TOTAL_W-1:0] white_total;
   } row_stats_type;

   typedef struct packed {
      logic               start;
      logic [SUM_W-1:0]   dividend;
      logic [TOTAL_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic               busy;
      logic               done;
      logic [SUM_W-1:0]   quotient;
   } div_rsp_type;

endpackage

// ===== rtl/lcs_req_if.sv =====
// pixel request channel, valid/ready handshake
// depends on nothing
interface lcs_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [7:0] pixel;
   logic       row_end;

   modport source (output valid, command, pixel, row_end, input ready);
   modport sink (input valid, command, pixel, row_end, output ready);
endinterface

// ===== rtl/lcs_rsp_if.sv =====
// result channel, valid/ready handshake
// depends on nothing
interface lcs_rsp_if;
   logic              valid;
   logic              ready;
   logic              result_kind;
   logic [7:0]        threshold_value;
   logic signed [8:0] line_error;
   logic [8:0]        white_count;
   logic              no_line;
   logic signed [8:0] right_drive;
   logic signed [8:0] left_drive;

   modport source (output valid, result_kind, threshold_value, line_error, white_count,
                   no_line, right_drive, left_drive, input ready);
   modport sink (input valid, result_kind, threshold_value, line_error, white_count,
                 no_line, right_drive, left_drive, output ready);
endinterface

// ===== rtl/lcs_csr_if.sv =====
// register write channel, valid/ready handshake
// depends on lcs_pkg for widths
interface lcs_csr_if;
   logic                           valid;
   logic                           ready;
   logic [lcs_pkg::CSR_INDEX_W-1:0] index;
   logic [lcs_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/line_centroid_steering_core.sv =====
// line centroid steering core: one pixel request per cycle within a row
// row-end calibrate request: threshold registered, then result loaded in ST_OUT
// track: ST_DIV (16-step sum/count divider; skipped if no white pixel), ST_MUL, ST_DRV, ST_OUT
// ready is low from a row-end request until its result is loaded into the output register
// synchronous active-high reset: registers back to 60 and -128, threshold and row state cleared
module line_centroid_steering_core #(
   parameter int ROW_WIDTH  = lcs_pkg::ROW_WIDTH_DEF,
   parameter int ROW_CENTRE = lcs_pkg::ROW_CENTRE_DEF
) (
   input logic      clock,
   input logic      reset,
   lcs_req_if.sink   req_chan,
   lcs_rsp_if.source rsp_chan,
   lcs_csr_if.sink   csr_chan
);
   localparam int SW = lcs_pkg::SUM_W;
   localparam int TW = lcs_pkg::TOTAL_W;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DIV  = 3'd1;
   localparam logic [2:0] ST_MUL  = 3'd2;
   localparam logic [2:0] ST_DRV  = 3'd3;
   localparam logic [2:0] ST_OUT  = 3'd4;

   logic [2:0]               state_ff, state_in;
   logic [7:0]               base_ff;
   logic signed [15:0]       gain_ff;
   logic [7:0]               thr_ff, thr_in;
   logic                     kind_ff, kind_in;
   logic                     neg_ff, neg_in;
   logic [TW-1:0]            total_ff, total_in;
   logic signed [8:0]        err_ff, err_in;
   logic signed [24:0]       prod_ff;
   logic signed [8:0]        right_ff, left_ff;
   logic                     rsp_valid_ff;
   logic                     req_take;
   logic                     rsp_take;
   logic                     out_load;
   logic [8:0]               minmax_sum;
   logic [SW-1:0]            sum_mag;
   logic [SW-1:0]            quo;
   logic signed [26:0]       base_q8;
   logic signed [26:0]       num_right;
   logic signed [26:0]       num_left;
   lcs_pkg::row_stats_type   stats_next;
   lcs_pkg::div_req_type     div_req;
   lcs_pkg::div_rsp_type     div_rsp;

   function automatic logic signed [8:0] q8_trunc_sat(input logic signed [26:0] num);
      logic [26:0] mag;
      logic [18:0] q;
      logic [8:0]  qs;
      mag = num[26] ? 27'(-num) : 27'(num);
      q   = mag[26:8];
      qs  = (q > 19'd255) ? 9'd255 : q[8:0];
      return num[26] ? $signed(-qs) : $signed(qs);
   endfunction

   lcs_row_acc #(
      .ROW_WIDTH  (ROW_WIDTH),
      .ROW_CENTRE (ROW_CENTRE)
   ) u_row_acc (
      .clock      (clock),
      .reset      (reset),
      .take       (req_take),
      .command    (req_chan.command),
      .pixel      (req_chan.pixel),
      .row_end    (req_chan.row_end),
      .threshold  (thr_ff),
      .stats_next (stats_next)
   );

   lcs_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_take       = req_chan.valid && req_chan.ready;
   assign rsp_take       = rsp_chan.valid && rsp_chan.ready;
   assign out_load       = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_chan.ready);
   assign csr_chan.ready = 1'b1;

   // sequencer
   always_comb begin
      minmax_sum = {1'b0, stats_next.row_max} + {1'b0, stats_next.row_min};
      sum_mag    = stats_next.offset_sum[SW-1] ? SW'(-stats_next.offset_sum)
                                               : stats_next.offset_sum;
      quo        = div_rsp.quotient;
      state_in   = state_ff;
      thr_in     = thr_ff;
      kind_in    = kind_ff;
      neg_in     = neg_ff;
      total_in   = total_ff;
      err_in     = err_ff;
      div_req.start    = 1'b0;
      div_req.dividend = sum_mag;
      div_req.divisor  = stats_next.white_total;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take && req_chan.row_end) begin
               kind_in = req_chan.command;
               if (req_chan.command == lcs_pkg::CMD_CALIBRATE) begin
                  thr_in   = minmax_sum[8:1];
                  state_in = ST_OUT;
               end else begin
                  neg_in   = stats_next.offset_sum[SW-1];
                  total_in = stats_next.white_total;
                  err_in   = '0;
                  if (stats_next.white_total == '0) begin
                     state_in = ST_MUL;
                  end else begin
                     div_req.start = 1'b1;
                     state_in      = ST_DIV;
                  end
               end
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               if (neg_ff) begin
                  err_in = (quo > SW'(256)) ? -9'sd256 : $signed(9'(-quo[8:0]));
               end else begin
                  err_in = (quo > SW'(255)) ? 9'sd255 : $signed(quo[8:0]);
               end
               state_in = ST_MUL;
            end
         end
         ST_MUL: state_in = ST_DRV;
         ST_DRV: state_in = ST_OUT;
         ST_OUT: begin
            if (out_load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // drive arithmetic
   always_comb begin
      base_q8   = $signed({11'd0, base_ff, 8'd0});
      num_right = base_q8 + 27'(prod_ff);
      num_left  = base_q8 - 27'(prod_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         base_ff      <= lcs_pkg::BASE_SPEED_RST;
         gain_ff      <= $signed(lcs_pkg::STEER_GAIN_RST);
         thr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         thr_ff   <= thr_in;
         if (csr_chan.valid && csr_chan.ready) begin
            unique case (csr_chan.index)
               lcs_pkg::REG_BASE_SPEED: base_ff <= csr_chan.data[7:0];
               lcs_pkg::REG_STEER_GAIN: gain_ff <= $signed(csr_chan.data);
               default: ;
            endcase
         end
         if (out_load) rsp_valid_ff <= 1'b1;
         else if (rsp_take) rsp_valid_ff <= 1'b0;
      end
      kind_ff  <= kind_in;
      neg_ff   <= neg_in;
      total_ff <= total_in;
      err_ff   <= err_in;
      if (state_ff == ST_MUL) prod_ff <= err_ff * gain_ff;
      if (state_ff == ST_DRV) begin
         right_ff <= q8_trunc_sat(num_right);
         left_ff  <= -q8_trunc_sat(num_left);
      end
      if (out_load) begin
         rsp_chan.result_kind     <= kind_ff;
         rsp_chan.threshold_value <= thr_ff;
         if (kind_ff == lcs_pkg::CMD_TRACK) begin
            rsp_chan.line_error  <= err_ff;
            rsp_chan.white_count <= total_ff;
            rsp_chan.no_line     <= (total_ff == '0);
            rsp_chan.right_drive <= right_ff;
            rsp_chan.left_drive  <= left_ff;
         end else begin
            rsp_chan.line_error  <= '0;
            rsp_chan.white_count <= '0;
            rsp_chan.no_line     <= 1'b0;
            rsp_chan.right_drive <= '0;
            rsp_chan.left_drive  <= '0;
         end
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;

`include "line_centroid_steering_core_assert.svh"

   `LCS_ASSERT_NOW(a_div_only_in_div, clock, reset, div_rsp.busy, state_ff == ST_DIV)
   `LCS_ASSERT_NEXT(a_row_end_busy, clock, reset, req_take && req_chan.row_end, !req_chan.ready)
   `LCS_ASSERT_NOW(a_no_line_zero_err, clock, reset, rsp_chan.valid && rsp_chan.no_line,
      rsp_chan.line_error == '0)
   `LCS_ASSERT_NOW(a_calib_zero, clock, reset,
      rsp_chan.valid && (rsp_chan.result_kind == lcs_pkg::CMD_CALIBRATE),
      rsp_chan.right_drive == '0 && rsp_chan.left_drive == '0 && rsp_chan.white_count == '0)
endmodule

// ===== rtl/lcs_divider.sv =====
// restoring divider, one quotient bit per cycle
// depends on lcs_pkg for request and status structs
module lcs_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  lcs_pkg::div_req_type div_req,
   output lcs_pkg::div_rsp_type div_rsp
);
   localparam int QW = lcs_pkg::SUM_W;
   localparam int DW = lcs_pkg::TOTAL_W;
   localparam int CW = $clog2(QW);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [QW-1:0] quo_ff, quo_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] dvs_ff, dvs_in;
   logic [DW:0]   trial;
   logic [DW:0]   shifted;

   always_comb begin
      shifted = {rem_ff, quo_ff[QW-1]};
      trial   = shifted - {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(QW - 1);
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         if (trial[DW]) begin
            rem_in = shifted[DW-1:0];
            quo_in = {quo_ff[QW-2:0], 1'b0};
         end else begin
            rem_in = trial[DW-1:0];
            quo_in = {quo_ff[QW-2:0], 1'b1};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;
endmodule

// ===== rtl/lcs_row_acc.sv =====
// per-pixel row accumulators: min, max, white offset sum and white count
// depends on lcs_pkg for the row statistics struct
module lcs_row_acc #(
   parameter int ROW_WIDTH  = lcs_pkg::ROW_WIDTH_DEF,
   parameter int ROW_CENTRE = lcs_pkg::ROW_CENTRE_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   take,
   input  logic                   command,
   input  logic [7:0]             pixel,
   input  logic                   row_end,
   input  logic [7:0]             threshold,
   output lcs_pkg::row_stats_type stats_next
);
   localparam int COL_W = $clog2(ROW_WIDTH + 1);
   localparam int SW    = lcs_pkg::SUM_W;
   localparam int TW    = lcs_pkg::TOTAL_W;

   logic [COL_W-1:0]       col_ff, col_in;
   lcs_pkg::row_stats_type stats_ff;
   logic                   active;
   logic [SW-1:0]          offset;

   always_comb begin
      active     = col_ff < COL_W'(ROW_WIDTH);
      offset     = SW'(col_ff) - SW'(ROW_CENTRE);
      stats_next = stats_ff;
      col_in     = col_ff;
      if (active) begin
         col_in = col_ff + 1'b1;
         if (command == lcs_pkg::CMD_CALIBRATE) begin
            if (pixel > stats_ff.row_max) stats_next.row_max = pixel;
            if (pixel < stats_ff.row_min) stats_next.row_min = pixel;
         end else if (pixel > threshold) begin
            stats_next.offset_sum = stats_ff.offset_sum + offset;
            if (stats_ff.white_total != {TW{1'b1}}) begin
               stats_next.white_total = stats_ff.white_total + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (take && row_end)) begin
         col_ff               <= '0;
         stats_ff.row_min     <= 8'hFF;
         stats_ff.row_max     <= '0;
         stats_ff.offset_sum  <= '0;
         stats_ff.white_total <= '0;
      end else if (take) begin
         col_ff   <= col_in;
         stats_ff <= stats_next;
      end
   end
endmodule
